[rtl/savitzky_golay_smoother_assert.svh]
// Assertion macros used by the smoother top level.
`ifndef SAVITZKY_GOLAY_SMOOTHER_ASSERT_SVH
`define SAVITZKY_GOLAY_SMOOTHER_ASSERT_SVH

`ifndef SYNTH
// Condition that must hold at every clock edge out of reset.
`define SGS_ASSERT_HOLD(label, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("smoother invariant violated");
// Condition that must hold in the cycle after a trigger.
`define SGS_ASSERT_NEXT(label, trig, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cond)) \
    else $error("smoother sequence violated");
`else
`define SGS_ASSERT_HOLD(label, cond)
`define SGS_ASSERT_NEXT(label, trig, cond)
`endif

`endif

[rtl/sgs_pkg.sv]
// Shared types and constants of the Savitzky-Golay smoother.
package sgs_pkg;

  // Coefficient format: signed Q2.16.
  localparam int COEF_BITS = 18;
  localparam int FRAC_BITS = 16;
  localparam int NUM_COEF  = 4;

  // Configuration register index width (indexes past the list are ignored).
  localparam int CFG_IDX_BITS = 3;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_COEF_CENTER = 3'd0,
    CFG_COEF_ONE    = 3'd1,
    CFG_COEF_TWO    = 3'd2,
    CFG_COEF_THREE  = 3'd3
  } cfg_reg_t;

  // Coefficient values after reset.
  localparam logic signed [COEF_BITS-1:0] COEF_CENTER_RST = 18'sd21845;
  localparam logic signed [COEF_BITS-1:0] COEF_ONE_RST    = 18'sd18725;
  localparam logic signed [COEF_BITS-1:0] COEF_TWO_RST    = 18'sd9362;
  localparam logic signed [COEF_BITS-1:0] COEF_THREE_RST  = -18'sd6242;

  // Control that travels with one output word down the pipeline.
  typedef struct packed {
    logic valid;
    logic filt;
    logic done;
  } tok_t;

endpackage

[rtl/sgs_cell.sv]
// One tap cell of the sample window: holds a sample and passes it on.
module sgs_cell #(
  parameter int SAMPLE_BITS = 16
) (
  input  logic                          clk,
  input  logic                          shift,
  input  logic signed [SAMPLE_BITS-1:0] d,
  output logic signed [SAMPLE_BITS-1:0] q
);

  // Take the neighbor's sample whenever the window moves.
  always_ff @(posedge clk) begin
    if (shift) begin
      q <= d;
    end
  end

endmodule

[rtl/sgs_pair_mul.sv]
// Symmetric tap pair: pre-adds two window samples and weights the sum.
module sgs_pair_mul #(
  parameter int SAMPLE_BITS = 16
) (
  input  logic                                     clk,
  input  logic                                     en,
  input  logic signed [SAMPLE_BITS-1:0]            near_tap,
  input  logic signed [SAMPLE_BITS-1:0]            far_tap,
  input  logic signed [sgs_pkg::COEF_BITS-1:0]     weight,
  output logic signed [SAMPLE_BITS+sgs_pkg::COEF_BITS:0] prod
);
  import sgs_pkg::*;

  logic signed [SAMPLE_BITS:0] pair_sum;

  // Both taps share one weight, so add them before the multiply.
  always_comb begin
    pair_sum = {near_tap[SAMPLE_BITS-1], near_tap} + {far_tap[SAMPLE_BITS-1], far_tap};
  end

  // Registered product.
  always_ff @(posedge clk) begin
    if (en) begin
      prod <= pair_sum * weight;
    end
  end

endmodule

[rtl/savitzky_golay_smoother.sv]
// Top level of the Savitzky-Golay row smoother.
//
//  channel  direction  handshake              payload
//  in       sink       in_valid / in_stall    sample_in, row_end
//  out      source     out_valid / out_stall  sample_out, was_filtered, row_done
//  cfg      sink       cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One sample is taken per clock while in_stall is low. A sample with row_end releases up to
// HALF_WINDOW + 1 words, one per clock while the output is not stalled, and in_stall stays
// high while two or more of them are still to launch. A word passes from the window through
// stage A and stage B into the output register, and tail words follow one another in order.
// The pipeline advances as a whole; out_stall with a valid output word holds every stage and stalls the input.
// Reset clears the pipeline tokens and the row position and restores the default coefficients;
// there is no clearing pass.
`include "savitzky_golay_smoother_assert.svh"

module savitzky_golay_smoother #(
  parameter int HALF_WINDOW = 3,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic signed [SAMPLE_BITS-1:0]          sample_in,
  input  logic                                   row_end,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic signed [SAMPLE_BITS-1:0]          sample_out,
  output logic                                   was_filtered,
  output logic                                   row_done,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [sgs_pkg::CFG_IDX_BITS-1:0]       cfg_index,
  input  logic signed [sgs_pkg::COEF_BITS-1:0]   cfg_data
);
  import sgs_pkg::*;

  localparam int WIN_LEN = 2 * HALF_WINDOW + 1;
  localparam int SEEN_W  = $clog2(WIN_LEN + 1);
  localparam int TL_W    = $clog2(HALF_WINDOW + 1);
  localparam int TI_W    = (HALF_WINDOW > 1) ? $clog2(HALF_WINDOW) : 1;
  localparam int PROD_W  = SAMPLE_BITS + COEF_BITS + 1;
  localparam int SUM_W   = PROD_W + 3;

  localparam logic signed [SUM_W-1:0] ROUND_HALF = SUM_W'(1) <<< (FRAC_BITS - 1);
  localparam logic signed [SUM_W-1:0] SAT_HI =
    {{(SUM_W - SAMPLE_BITS + 1){1'b0}}, {(SAMPLE_BITS - 1){1'b1}}};
  localparam logic signed [SUM_W-1:0] SAT_LO = ~SAT_HI;

  // Coefficient registers.
  logic signed [COEF_BITS-1:0] coef [NUM_COEF];

  // Window taps, index 0 is the newest sample.
  logic signed [SAMPLE_BITS-1:0] taps [WIN_LEN];
  logic signed [SAMPLE_BITS-1:0] tail_taps [HALF_WINDOW];

  // Row position and words still to launch.
  logic [SEEN_W-1:0] seen;
  logic [SEEN_W-1:0] seen_inc;
  logic              pend_ctr;
  logic              pend_full;
  logic [TL_W-1:0]   tail_left;
  logic [TL_W-1:0]   tail_new;
  logic [TI_W-1:0]   tail_idx;

  logic adv;
  logic in_acc;
  logic launch;

  // Pipeline stages.
  tok_t                          a_tok;
  logic signed [SAMPLE_BITS-1:0] a_pass;
  logic signed [PROD_W-1:0]      a_prod [HALF_WINDOW+1];
  tok_t                          b_tok;
  logic signed [SAMPLE_BITS-1:0] b_pass;
  logic signed [SUM_W-1:0]       b_sum;
  logic signed [SUM_W-1:0]       b_sum_next;
  logic signed [SUM_W-1:0]       rounded;

  // Configuration writes are always taken.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      coef[0] <= COEF_CENTER_RST;
      coef[1] <= COEF_ONE_RST;
      coef[2] <= COEF_TWO_RST;
      coef[3] <= COEF_THREE_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_COEF_CENTER: coef[0] <= cfg_data;
        CFG_COEF_ONE:    coef[1] <= cfg_data;
        CFG_COEF_TWO:    coef[2] <= cfg_data;
        CFG_COEF_THREE:  coef[3] <= cfg_data;
        default: ;
      endcase
    end
  end

  // The whole pipeline moves when the output register is free or being taken.
  assign adv    = !out_valid || !out_stall;
  assign launch = pend_ctr || (tail_left != '0);

  // A new sample enters only when at most one word is pending and it leaves now.
  assign in_stall = !adv || (pend_ctr && (tail_left != '0)) || (tail_left > TL_W'(1));
  assign in_acc   = in_valid && !in_stall;

  // Chain of window cells.
  for (genvar i = 0; i < WIN_LEN; i++) begin : g_cell
    logic signed [SAMPLE_BITS-1:0] cell_d;
    if (i == 0) begin : g_head
      assign cell_d = sample_in;
    end else begin : g_body
      assign cell_d = taps[i-1];
    end
    sgs_cell #(.SAMPLE_BITS(SAMPLE_BITS)) u_cell (
      .clk   (clk),
      .shift (in_acc),
      .d     (cell_d),
      .q     (taps[i])
    );
  end

  for (genvar i = 0; i < HALF_WINDOW; i++) begin : g_tail
    assign tail_taps[i] = taps[i];
  end

  // Symmetric pairs; the center uses the same cell with an empty far tap.
  for (genvar k = 0; k <= HALF_WINDOW; k++) begin : g_pair
    logic signed [SAMPLE_BITS-1:0] far_tap;
    logic signed [COEF_BITS-1:0]   weight;
    if (k == 0) begin : g_ctr
      assign far_tap = '0;
    end else begin : g_side
      assign far_tap = taps[HALF_WINDOW+k];
    end
    if (k < NUM_COEF) begin : g_w
      assign weight = coef[k];
    end else begin : g_zero
      assign weight = '0;
    end
    sgs_pair_mul #(.SAMPLE_BITS(SAMPLE_BITS)) u_pair (
      .clk      (clk),
      .en       (adv),
      .near_tap (taps[HALF_WINDOW-k]),
      .far_tap  (far_tap),
      .weight   (weight),
      .prod     (a_prod[k])
    );
  end

  // Row position for the sample being taken.
  always_comb begin
    seen_inc = (seen == SEEN_W'(WIN_LEN)) ? seen : seen + SEEN_W'(1);
    tail_new = (seen_inc > SEEN_W'(HALF_WINDOW)) ? TL_W'(HALF_WINDOW) : TL_W'(seen_inc);
    tail_idx = TI_W'(tail_left - TL_W'(1));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seen      <= '0;
      pend_ctr  <= 1'b0;
      pend_full <= 1'b0;
      tail_left <= '0;
    end else if (in_acc) begin
      seen      <= row_end ? '0 : seen_inc;
      pend_ctr  <= seen_inc > SEEN_W'(HALF_WINDOW);
      pend_full <= seen_inc == SEEN_W'(WIN_LEN);
      tail_left <= row_end ? tail_new : '0;
    end else if (adv) begin
      if (pend_ctr) begin
        pend_ctr <= 1'b0;
      end else if (tail_left != '0) begin
        tail_left <= tail_left - TL_W'(1);
      end
    end
  end

  // Stage A: launch one word from the window; products land in the pair cells.
  always_ff @(posedge clk) begin
    if (rst) begin
      a_tok <= '0;
    end else if (adv) begin
      a_tok.valid <= launch;
      a_tok.filt  <= pend_ctr && pend_full;
      a_tok.done  <= !pend_ctr && (tail_left == TL_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_pass <= pend_ctr ? taps[HALF_WINDOW] : tail_taps[tail_idx];
    end
  end

  // Stage B: sum the weighted pairs with half an LSB for rounding.
  always_comb begin
    b_sum_next = ROUND_HALF;
    for (int k = 0; k <= HALF_WINDOW; k++) begin
      b_sum_next = b_sum_next + SUM_W'(a_prod[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_tok <= '0;
    end else if (adv) begin
      b_tok <= a_tok;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      b_pass <= a_pass;
      b_sum  <= b_sum_next;
    end
  end

  // Stage C: floor filtered sums to whole samples and clamp to the sample range, or pass the sample through.
  assign rounded = b_sum >>> FRAC_BITS;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= b_tok.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      was_filtered <= b_tok.filt;
      row_done     <= b_tok.done;
      if (!b_tok.filt) begin
        sample_out <= b_pass;
      end else if (rounded > SAT_HI) begin
        sample_out <= SAT_HI[SAMPLE_BITS-1:0];
      end else if (rounded < SAT_LO) begin
        sample_out <= SAT_LO[SAMPLE_BITS-1:0];
      end else begin
        sample_out <= rounded[SAMPLE_BITS-1:0];
      end
    end
  end

  // A row end always leaves at least one tail word to flush.
  `SGS_ASSERT_NEXT(a_row_end_flushes, in_acc && row_end, tail_left != '0)
  // The tail never holds more than the half window.
  `SGS_ASSERT_HOLD(a_tail_bound, tail_left <= TL_W'(HALF_WINDOW))
  // The closing word of a row is always a passed-through sample.
  `SGS_ASSERT_HOLD(a_done_not_filtered, !(out_valid && was_filtered && row_done))
  // A launched word occupies stage A on the next cycle.
  `SGS_ASSERT_NEXT(a_launch_fills_stage, adv && launch, a_tok.valid)

endmodule
